// File: sv/cbi_pkg.sv
`timescale 1ns / 1ps

package cbi_pkg;

    // Interleaver geometry
    localparam int BRANCHES   = 12;
    localparam int UNIT_DEPTH = 17;
    localparam int STORE_SIZE = UNIT_DEPTH * BRANCHES * (BRANCHES - 1) / 2;

    localparam int DATA_W = 8;
    localparam int ADDR_W = $clog2(STORE_SIZE);
    localparam int BR_W   = $clog2(BRANCHES);
    // wide enough for the longest branch length itself
    localparam int PTR_W  = $clog2(UNIT_DEPTH * (BRANCHES - 1) + 1);

    // Per-request view of the current branch
    typedef struct packed {
        logic              pass;    // branch 0: no delay
        logic              filled;  // branch has wrapped once, store holds real data
        logic [ADDR_W-1:0] addr;    // delay store entry for this request
    } t_slot;

endpackage

// File: sv/cbi_ram.sv
`timescale 1ns / 1ps

module cbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1122,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic [AW-1:0]    i_addr,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read and write at the same address return the old entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/cbi_seq.sv
`timescale 1ns / 1ps

module cbi_seq import cbi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_advance,
    output t_slot o_slot
);

    logic [BR_W-1:0]   r_branch, n_branch;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [PTR_W-1:0]  r_len, n_len;
    logic [PTR_W-1:0]  r_ptr [BRANCHES];
    logic [BRANCHES-1:0] r_full;

    logic [PTR_W-1:0] w_ptr;
    logic [PTR_W-1:0] w_ptr_inc;
    logic             w_wrap;
    logic             w_last;

    assign w_ptr     = r_ptr[r_branch];
    assign w_ptr_inc = w_ptr + 1'b1;
    assign w_wrap    = (w_ptr_inc == r_len);
    assign w_last    = (r_branch == BR_W'(BRANCHES - 1));

    // Walk branch base and length along with the index: adds only
    always_comb begin
        if (w_last) begin
            n_branch = '0;
            n_base   = '0;
            n_len    = '0;
        end else begin
            n_branch = r_branch + 1'b1;
            n_base   = r_base + ADDR_W'(r_len);
            n_len    = r_len + PTR_W'(UNIT_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch <= '0;
            r_base   <= '0;
            r_len    <= '0;
            r_full   <= '0;
            for (int k = 0; k < BRANCHES; k++) begin
                r_ptr[k] <= '0;
            end
        end else if (i_advance) begin
            r_branch <= n_branch;
            r_base   <= n_base;
            r_len    <= n_len;
            if (r_branch != '0) begin
                r_ptr[r_branch] <= w_wrap ? '0 : w_ptr_inc;
                if (w_wrap) begin
                    r_full[r_branch] <= 1'b1;
                end
            end
        end
    end

    assign o_slot.pass   = (r_branch == '0);
    assign o_slot.filled = r_full[r_branch];
    assign o_slot.addr   = r_base + ADDR_W'(w_ptr);

endmodule

// File: sv/convolutional_byte_interleaver_unit.sv
`timescale 1ns / 1ps
// Path: an accepted byte passes through stage 1 and then the output register on its way to o_data_out.
// Throughput: one byte per cycle while the output is not stalled, set by the single delay-store port doing one
//   read-first access (read oldest byte, write new byte) per request on branches other than 0.
// Reset: synchronous, active low; clears branch index, pointers and per-branch fill flags.
//   No clearing pass over the store: a branch reads as zero until it has wrapped once.
module convolutional_byte_interleaver_unit import cbi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_data_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_data_out
);

    t_slot             w_slot;
    logic              w_accept;
    logic              w_mem_access;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_s1_data;
    logic              w_s1_adv;

    // Stage 1: request has issued its store access, read data due this cycle
    logic              r_s1_valid;
    logic              r_s1_pass;
    logic              r_s1_filled;
    logic [DATA_W-1:0] r_s1_byte;

    // Output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    // Advance stage 1 into the output register when it is free or draining
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    // Take a new request only when stage 1 frees up, so the RAM read data holds
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    // Branch sequencer: index, per-branch pointers and fill flags
    cbi_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_accept),
        .o_slot    (w_slot)
    );

    // Branch 0 bypasses the store entirely.
    // An entry is touched again only after a full branch cycle, so no forwarding is needed.
    assign w_mem_access = w_accept && !w_slot.pass;

    cbi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_addr  (w_slot.addr),
        .i_we    (w_mem_access),
        .i_re    (w_mem_access),
        .i_wdata (i_data_in),
        .o_rdata (w_rdata)
    );

    // Pick the bypass byte, the stored byte, or zero for a branch not yet filled
    always_comb begin
        if (r_s1_pass) begin
            w_s1_data = r_s1_byte;
        end else if (r_s1_filled) begin
            w_s1_data = w_rdata;
        end else begin
            w_s1_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= w_accept;
        end
    end

    // Hold stage-1 payload until it moves on
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pass   <= w_slot.pass;
            r_s1_filled <= w_slot.filled;
            r_s1_byte   <= i_data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data <= w_s1_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;

    // Store address stays inside the delay store
    a_addr_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_access |-> (w_slot.addr < ADDR_W'(STORE_SIZE)))
        else $error("delay store address out of range");

    // A branch-0 request carries its own byte into stage 1
    a_bypass : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_slot.pass) |=> (r_s1_valid && r_s1_pass && r_s1_byte == $past(i_data_in)))
        else $error("bypass byte lost");

    // A stalled stage 1 keeps its request and no new store read is issued
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |-> (!w_mem_access ##1 (r_s1_valid && $stable(r_s1_byte))))
        else $error("stage 1 overwritten while stalled");

endmodule
